[rtl/core/cra_pkg.sv]
// Shared constants and codes of the chunked range allocator.
`timescale 1ns / 1ps
`default_nettype none
package cra_pkg;
	localparam int START_W  = 18;
	localparam int LEN_W    = 9;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int ENTRY_W  = START_W + LEN_W;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_QUEUE = 2'd1,
		ACT_DRAIN = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_NO_CHUNK = 3'd3,
		ST_FULL     = 3'd4,
		ST_IGNORED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} entry_t;
endpackage
`default_nettype wire

[rtl/core/cra_in_if.sv]
// Request channel of the chunked range allocator.
`timescale 1ns / 1ps
`default_nettype none
interface cra_in_if;
	logic                         valid;
	logic                         ready;
	logic [cra_pkg::ACTION_W-1:0] action;
	logic [cra_pkg::START_W-1:0]  range_start;
	logic [cra_pkg::LEN_W-1:0]    range_length;
	modport source (output valid, action, range_start, range_length, input ready);
	modport sink (input valid, action, range_start, range_length, output ready);
endinterface
`default_nettype wire

[rtl/core/cra_out_if.sv]
// Result channel of the chunked range allocator.
`timescale 1ns / 1ps
`default_nettype none
interface cra_out_if;
	logic                         valid;
	logic                         ready;
	logic [cra_pkg::START_W-1:0]  given_start;
	logic [cra_pkg::STATUS_W-1:0] status;
	logic                         range_dropped;
	modport source (output valid, given_start, status, range_dropped, input ready);
	modport sink (input valid, given_start, status, range_dropped, output ready);
endinterface
`default_nettype wire

[rtl/core/chunked_range_allocator_top.sv]
// Chunked first-fit range allocator: sequencer around free and pending list memories.
//
// Usage: requests enter on in_ch (action, range_start, range_length); every request
// gives exactly one result beat on out_ch (given_start, status, range_dropped).
// One request is worked on at a time; in_ch.ready is high only while the sequencer
// is idle. The result sits in an output register, so the next request is taken while
// a finished result still waits for out_ch.ready.
// Work per request, serialized by the single read port of each list memory:
//   queue, bad length, unknown action: straight to the result register.
//   alloc: scans the free entries, else takes the current or a new chunk; exact fits remove.
//   drain: per pending entry it compares the free entries, may look for a second
//   neighbor among them, and removes that neighbor when it merges with it.
// Reset (arst_n low) empties both lists and forgets all chunks at once; the list
// memories are not cleared, only entries below the fill counts are ever used.
// A stalled receiver holds the result register; a further finished result waits
// in the sequencer until the register is taken.
`timescale 1ns / 1ps
`default_nettype none
module chunked_range_allocator_top #(
	parameter int CHUNK_SHIFT   = 8,
	parameter int MAX_CHUNKS    = 1024,
	parameter int FREE_DEPTH    = 64,
	parameter int PENDING_DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cra_in_if.sink     in_ch,
	cra_out_if.source  out_ch
);
	localparam int SW   = cra_pkg::START_W;
	localparam int LW   = cra_pkg::LEN_W;
	localparam int FW   = CHUNK_SHIFT + 1;
	localparam int CW   = (CHUNK_SHIFT + 2 > LW + 1) ? CHUNK_SHIFT + 2 : LW + 1;
	localparam int CHW  = $clog2(MAX_CHUNKS + 1);
	localparam int FUW  = $clog2(FREE_DEPTH + 1);
	localparam int FAW  = $clog2(FREE_DEPTH);
	localparam int PUW  = $clog2(PENDING_DEPTH + 1);
	localparam int PAW  = $clog2(PENDING_DEPTH);
	localparam logic [CW-1:0] CHUNK_SIZE = CW'(1) << CHUNK_SHIFT;

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CK, S_BUMP, S_RM_RD, S_RM_WR, S_D_RD, S_D_LD,
		S_F_RD, S_F_CK, S_J_RD, S_J_CK, S_PUSH, S_FIN
	} state_t;

	state_t state_q;

	cra_pkg::entry_t free_mem [FREE_DEPTH];
	cra_pkg::entry_t pend_mem [PENDING_DEPTH];
	cra_pkg::entry_t f_rdata_q, p_rdata_q, f_wd, p_wd;
	logic f_we, p_we;
	logic [FAW-1:0] f_wa, f_ra;
	logic [PAW-1:0] p_wa;

	logic [FUW-1:0] free_used_q, idx_q, jdx_q, rm_idx_q;
	logic [PUW-1:0] pend_used_q, d_q;
	logic [CHW-1:0] chunks_q;
	logic [FW-1:0]  fill_q;
	logic [SW-1:0]  start_q, istart_q, given_q;
	logic [LW-1:0]  len_q, ilen_q;
	cra_pkg::status_t status_q;
	logic drop_q, drain_q;
	logic           out_valid_q;
	logic [SW-1:0]  out_start_q;
	logic [cra_pkg::STATUS_W-1:0] out_status_q;
	logic           out_drop_q;

	// Decode of the free entry read last cycle, and of the request and output handshakes
	cra_pkg::entry_t e;
	logic [SW:0]   end_w, e_end;
	logic          same_chunk, adj_lo, adj_hi, fits, exact, j_hit;
	logic [LW:0]   sum_a, sum_j;
	logic [LW-1:0] sat_a, sat_j;
	logic [CW-1:0] fill_plus;
	logic          need_new, tail_push, free_room, accept, too_long;
	logic          out_load;

	always_comb begin
		e          = f_rdata_q;
		end_w      = {1'b0, start_q} + (SW+1)'(len_q);
		e_end      = {1'b0, e.start} + (SW+1)'(e.len);
		same_chunk = (e.start >> CHUNK_SHIFT) == (start_q >> CHUNK_SHIFT);
		adj_lo     = same_chunk && (e_end == {1'b0, start_q});
		adj_hi     = same_chunk && ({1'b0, e.start} == end_w);
		j_hit      = (jdx_q != idx_q) && adj_hi;
		sum_a      = {1'b0, e.len} + {1'b0, len_q};
		sat_a      = sum_a[LW] ? cra_pkg::LEN_MAX : sum_a[LW-1:0];
		sum_j      = {1'b0, ilen_q} + {1'b0, e.len};
		sat_j      = sum_j[LW] ? cra_pkg::LEN_MAX : sum_j[LW-1:0];
		fits       = e.len >= len_q;
		exact      = e.len == len_q;
		fill_plus  = CW'(fill_q) + CW'(len_q);
		need_new   = (chunks_q == '0) || (fill_plus > CHUNK_SIZE);
		tail_push  = (chunks_q != '0) && (CW'(fill_q) < CHUNK_SIZE);
		free_room  = free_used_q < FUW'(FREE_DEPTH);
		accept     = in_ch.valid && in_ch.ready;
		too_long   = CW'(in_ch.range_length) > CHUNK_SIZE;
		out_load   = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);
	end

	always_comb begin
		f_we = 1'b0;
		f_wa = idx_q[FAW-1:0];
		f_wd = '0;
		case (state_q)
			S_A_CK: begin
				f_we = fits && !exact;
				f_wd = '{start: e.start + SW'(len_q), len: e.len - len_q};
			end
			S_BUMP: begin
				f_we = need_new && (chunks_q < CHW'(MAX_CHUNKS)) && tail_push && free_room;
				f_wa = free_used_q[FAW-1:0];
				f_wd = '{start: SW'((32'(chunks_q - CHW'(1)) << CHUNK_SHIFT) + 32'(fill_q)),
					len: LW'(CHUNK_SIZE - CW'(fill_q))};
			end
			S_RM_WR: begin
				f_we = 1'b1;
				f_wa = rm_idx_q[FAW-1:0];
				f_wd = f_rdata_q;
			end
			S_F_CK: begin
				f_we = adj_lo || adj_hi;
				f_wd = '{start: adj_lo ? e.start : start_q, len: sat_a};
			end
			S_J_CK: begin
				f_we = j_hit;
				f_wd = '{start: istart_q, len: sat_j};
			end
			S_PUSH: begin
				f_we = free_room;
				f_wa = free_used_q[FAW-1:0];
				f_wd = '{start: start_q, len: len_q};
			end
			default: f_we = 1'b0;
		endcase
		case (state_q)
			S_RM_RD: f_ra = FAW'(free_used_q - FUW'(1));
			S_J_RD:  f_ra = jdx_q[FAW-1:0];
			default: f_ra = idx_q[FAW-1:0];
		endcase
		p_we = accept && (in_ch.action == cra_pkg::ACT_QUEUE) && (in_ch.range_length != '0)
			&& !too_long && (pend_used_q < PUW'(PENDING_DEPTH));
		p_wa = pend_used_q[PAW-1:0];
		p_wd = '{start: in_ch.range_start, len: in_ch.range_length};
	end

	always_ff @(posedge clk) begin
		if (f_we) free_mem[f_wa] <= f_wd;
		f_rdata_q <= free_mem[f_ra];
		if (p_we) pend_mem[p_wa] <= p_wd;
		p_rdata_q <= pend_mem[d_q[PAW-1:0]];
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.given_start   = out_start_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.range_dropped = out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_used_q <= '0;
			pend_used_q <= '0;
			chunks_q    <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						start_q <= in_ch.range_start;
						len_q   <= in_ch.range_length;
						given_q <= '0;
						drop_q  <= 1'b0;
						idx_q   <= '0;
						d_q     <= '0;
						case (in_ch.action)
							cra_pkg::ACT_ALLOC: begin
								if (in_ch.range_length == '0) begin
									status_q <= cra_pkg::ST_ZERO;
									state_q  <= S_FIN;
								end else if (too_long) begin
									status_q <= cra_pkg::ST_TOO_LONG;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_A_RD;
								end
							end
							cra_pkg::ACT_QUEUE: begin
								state_q <= S_FIN;
								if (in_ch.range_length == '0) status_q <= cra_pkg::ST_ZERO;
								else if (too_long) status_q <= cra_pkg::ST_TOO_LONG;
								else if (!p_we) status_q <= cra_pkg::ST_FULL;
								else begin
									status_q    <= cra_pkg::ST_OK;
									pend_used_q <= pend_used_q + PUW'(1);
								end
							end
							cra_pkg::ACT_DRAIN: state_q <= S_D_RD;
							default: begin
								status_q <= cra_pkg::ST_IGNORED;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_A_RD: state_q <= (idx_q == free_used_q) ? S_BUMP : S_A_CK;
				S_A_CK: begin
					if (fits) begin
						given_q  <= e.start;
						status_q <= cra_pkg::ST_OK;
						if (exact) begin
							rm_idx_q <= idx_q;
							drain_q  <= 1'b0;
							state_q  <= S_RM_RD;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						idx_q   <= idx_q + FUW'(1);
						state_q <= S_A_RD;
					end
				end
				S_BUMP: begin
					state_q <= S_FIN;
					if (need_new && chunks_q >= CHW'(MAX_CHUNKS)) begin
						status_q <= cra_pkg::ST_NO_CHUNK;
					end else begin
						status_q <= cra_pkg::ST_OK;
						if (need_new) begin
							if (tail_push) begin
								if (free_room) free_used_q <= free_used_q + FUW'(1);
								else drop_q <= 1'b1;
							end
							chunks_q <= chunks_q + CHW'(1);
							given_q  <= SW'(32'(chunks_q) << CHUNK_SHIFT);
							fill_q   <= FW'(len_q);
						end else begin
							given_q <= SW'((32'(chunks_q - CHW'(1)) << CHUNK_SHIFT)
								+ 32'(fill_q));
							fill_q  <= FW'(fill_plus);
						end
					end
				end
				S_RM_RD: state_q <= S_RM_WR;
				S_RM_WR: begin
					free_used_q <= free_used_q - FUW'(1);
					if (drain_q) begin
						d_q     <= d_q + PUW'(1);
						state_q <= S_D_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_D_RD: begin
					if (d_q == pend_used_q) begin
						pend_used_q <= '0;
						status_q    <= cra_pkg::ST_OK;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_D_LD;
					end
				end
				S_D_LD: begin
					start_q <= p_rdata_q.start;
					len_q   <= p_rdata_q.len;
					idx_q   <= '0;
					state_q <= S_F_RD;
				end
				S_F_RD: state_q <= (idx_q == free_used_q) ? S_PUSH : S_F_CK;
				S_F_CK: begin
					if (adj_lo) begin
						istart_q <= e.start;
						ilen_q   <= sat_a;
						jdx_q    <= '0;
						state_q  <= S_J_RD;
					end else if (adj_hi) begin
						d_q     <= d_q + PUW'(1);
						state_q <= S_D_RD;
					end else begin
						idx_q   <= idx_q + FUW'(1);
						state_q <= S_F_RD;
					end
				end
				S_J_RD: begin
					if (jdx_q == free_used_q) begin
						d_q     <= d_q + PUW'(1);
						state_q <= S_D_RD;
					end else begin
						state_q <= S_J_CK;
					end
				end
				S_J_CK: begin
					if (j_hit) begin
						rm_idx_q <= jdx_q;
						drain_q  <= 1'b1;
						state_q  <= S_RM_RD;
					end else begin
						jdx_q   <= jdx_q + FUW'(1);
						state_q <= S_J_RD;
					end
				end
				S_PUSH: begin
					if (free_room) free_used_q <= free_used_q + FUW'(1);
					else drop_q <= 1'b1;
					d_q     <= d_q + PUW'(1);
					state_q <= S_D_RD;
				end
				S_FIN: begin
					if (out_load) begin
						out_start_q  <= (status_q == cra_pkg::ST_OK) ? given_q : '0;
						out_status_q <= status_q;
						out_drop_q   <= drop_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_used_q <= FUW'(FREE_DEPTH)) else $error("free list count overflow");
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_used_q <= PUW'(PENDING_DEPTH)) else $error("pending count overflow");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= CHUNK_SIZE) else $error("chunk fill beyond chunk size");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_CK || state_q == S_F_CK) |-> idx_q < free_used_q)
		else $error("scan read past free list");
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM_RD) |-> (free_used_q != '0 && rm_idx_q < free_used_q))
		else $error("removal from empty free list");
`endif
endmodule
`default_nettype wire
